### rtl/core/wav_hdr_pkg.sv
// ----------------------------------------------------------------------------
// wav_hdr_pkg
// Types and constants shared by the WAV header parser modules.
// ----------------------------------------------------------------------------
package wav_hdr_pkg;

	// One input transfer: a file byte with its framing flags
	typedef struct packed {
		logic [7:0] in_byte;
		logic       first_byte;
		logic       final_byte;
	} wav_hdr_in_t;

	// One result transfer
	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] channel_count;
		logic [31:0] rate_hz;
		logic [15:0] bits_per_sample;
		logic [31:0] data_size;
	} wav_hdr_out_t;

	// Status codes
	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_NO_RIFF = 3'd1;
	localparam logic [2:0] ST_NO_WAVE = 3'd2;
	localparam logic [2:0] ST_NOT_PCM = 3'd3;
	localparam logic [2:0] ST_NO_DATA = 3'd4;
	localparam logic [2:0] ST_TRUNC   = 3'd5;

	// Chunk tags as little-endian words
	localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
	localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
	localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
	localparam logic [31:0] TAG_DATA = 32'h6174_6164;

	localparam logic [15:0] FMT_PCM        = 16'h0001;
	localparam logic [15:0] FMT_EXTENSIBLE = 16'hFFFE;

	localparam logic [31:0] BASIC_FMT_BYTES = 32'd16;
	localparam logic [31:0] EXT_FMT_BYTES   = 32'd40;
	localparam logic [31:0] EXT_SKIP_FIRST  = 32'd8;
	localparam logic [31:0] EXT_SKIP_SECOND = 32'd14;

endpackage

### rtl/core/wav_hdr_fsm.sv
// ----------------------------------------------------------------------------
// wav_hdr_fsm
// Parse state and one-byte step logic of the WAV header parser.
// ----------------------------------------------------------------------------
module wav_hdr_fsm
	import wav_hdr_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         valid,
	input  logic         advance,
	input  wav_hdr_in_t  item,
	output logic         emit,
	output wav_hdr_out_t result
);

	typedef enum logic [4:0] {
		PH_RIFF, PH_RSIZE, PH_WAVE, PH_CID, PH_CSIZE, PH_CSKIP, PH_FSIZE,
		PH_FORMAT, PH_CHAN, PH_RATE, PH_BRATE, PH_ALIGN, PH_BITS, PH_EXT1,
		PH_SUBFMT, PH_EXT2, PH_FSKIP, PH_DID, PH_DSIZE
	} phase_t;

	phase_t      phase_q,    c_phase,    n_phase;
	logic [1:0]  idx_q,      c_idx,      n_idx;
	logic [31:0] word_q,     c_word,     n_word;
	logic [31:0] skip_q,     c_skip,     n_skip;
	logic [31:0] fmt_len_q,  c_fmt_len,  n_fmt_len;
	logic [15:0] fmt_q,      c_fmt,      n_fmt;
	logic [15:0] chan_q,     c_chan,     n_chan;
	logic [31:0] rate_q,     c_rate,     n_rate;
	logic [15:0] bits_q,     c_bits,     n_bits;
	logic        done_q,     c_done,     n_done;

	logic [31:0] word_sh;
	logic [31:0] skip_dec;
	logic [31:0] ext_rest;
	logic [31:0] basic_rest;
	logic [31:0] v;
	logic        fld_2;
	logic        hit;
	logic [2:0]  code;

	always_comb begin
		// a restart flag clears the state ahead of this byte
		if (item.first_byte) begin
			c_phase   = PH_RIFF;
			c_idx     = '0;
			c_word    = '0;
			c_skip    = '0;
			c_fmt_len = '0;
			c_fmt     = '0;
			c_chan    = '0;
			c_rate    = '0;
			c_bits    = '0;
			c_done    = 1'b0;
		end else begin
			c_phase   = phase_q;
			c_idx     = idx_q;
			c_word    = word_q;
			c_skip    = skip_q;
			c_fmt_len = fmt_len_q;
			c_fmt     = fmt_q;
			c_chan    = chan_q;
			c_rate    = rate_q;
			c_bits    = bits_q;
			c_done    = done_q;
		end

		n_phase   = c_phase;
		n_idx     = c_idx;
		n_word    = c_word;
		n_skip    = c_skip;
		n_fmt_len = c_fmt_len;
		n_fmt     = c_fmt;
		n_chan    = c_chan;
		n_rate    = c_rate;
		n_bits    = c_bits;
		n_done    = c_done;
		hit       = 1'b0;
		code      = ST_OK;

		word_sh    = {item.in_byte, c_word[31:8]};
		skip_dec   = c_skip - 32'd1;
		ext_rest   = c_fmt_len - EXT_FMT_BYTES;
		basic_rest = c_fmt_len - BASIC_FMT_BYTES;
		fld_2      = (c_phase == PH_FORMAT) || (c_phase == PH_CHAN) ||
			(c_phase == PH_ALIGN) || (c_phase == PH_BITS) || (c_phase == PH_SUBFMT);
		v          = fld_2 ? {16'h0000, word_sh[31:16]} : word_sh;

		if (!c_done) begin
			if ((c_phase == PH_CSKIP) || (c_phase == PH_EXT1) ||
				(c_phase == PH_EXT2) || (c_phase == PH_FSKIP)) begin
				n_skip = skip_dec;
				if (skip_dec == '0) begin
					case (c_phase)
						PH_CSKIP: n_phase = PH_CID;
						PH_EXT1:  n_phase = PH_SUBFMT;
						PH_EXT2: begin
							if (ext_rest == '0) begin
								n_phase = PH_DID;
							end else begin
								n_skip  = ext_rest;
								n_phase = PH_FSKIP;
							end
						end
						default:  n_phase = PH_DID;
					endcase
				end
			end else begin
				n_word = word_sh;
				if (fld_2 ? (c_idx == 2'd0) : (c_idx != 2'd3)) begin
					n_idx = c_idx + 2'd1;
				end else begin
					n_idx = '0;
					case (c_phase)
						PH_RIFF: begin
							if (v != TAG_RIFF) begin
								hit  = 1'b1;
								code = ST_NO_RIFF;
							end else begin
								n_phase = PH_RSIZE;
							end
						end
						PH_RSIZE: n_phase = PH_WAVE;
						PH_WAVE: begin
							if (v != TAG_WAVE) begin
								hit  = 1'b1;
								code = ST_NO_WAVE;
							end else begin
								n_phase = PH_CID;
							end
						end
						PH_CID:   n_phase = (v == TAG_FMT) ? PH_FSIZE : PH_CSIZE;
						PH_CSIZE: begin
							if (v == '0) begin
								n_phase = PH_CID;
							end else begin
								n_skip  = v;
								n_phase = PH_CSKIP;
							end
						end
						PH_FSIZE: begin
							n_fmt_len = v;
							n_phase   = PH_FORMAT;
						end
						PH_FORMAT: begin
							n_fmt   = v[15:0];
							n_phase = PH_CHAN;
						end
						PH_CHAN: begin
							n_chan  = v[15:0];
							n_phase = PH_RATE;
						end
						PH_RATE: begin
							n_rate  = v;
							n_phase = PH_BRATE;
						end
						PH_BRATE: n_phase = PH_ALIGN;
						PH_ALIGN: n_phase = PH_BITS;
						PH_BITS: begin
							n_bits = v[15:0];
							if (c_fmt == FMT_EXTENSIBLE) begin
								n_skip  = EXT_SKIP_FIRST;
								n_phase = PH_EXT1;
							end else if (c_fmt != FMT_PCM) begin
								hit  = 1'b1;
								code = ST_NOT_PCM;
							end else if (basic_rest == '0) begin
								n_phase = PH_DID;
							end else begin
								n_skip  = basic_rest;
								n_phase = PH_FSKIP;
							end
						end
						PH_SUBFMT: begin
							n_fmt = v[15:0];
							if (v[15:0] != FMT_PCM) begin
								hit  = 1'b1;
								code = ST_NOT_PCM;
							end else begin
								n_skip  = EXT_SKIP_SECOND;
								n_phase = PH_EXT2;
							end
						end
						PH_DID: begin
							if (v != TAG_DATA) begin
								hit  = 1'b1;
								code = ST_NO_DATA;
							end else begin
								n_phase = PH_DSIZE;
							end
						end
						default: begin
							// data size word closes the header
							hit  = 1'b1;
							code = ST_OK;
						end
					endcase
				end
			end
			if (!hit && item.final_byte) begin
				hit  = 1'b1;
				code = ST_TRUNC;
			end
		end

		if (hit) begin
			n_done = 1'b1;
		end

		emit                   = valid && hit;
		result.status          = code;
		result.channel_count   = n_chan;
		result.rate_hz         = n_rate;
		result.bits_per_sample = n_bits;
		result.data_size       = (code == ST_OK) ? n_word : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_RIFF;
			idx_q     <= '0;
			word_q    <= '0;
			skip_q    <= '0;
			fmt_len_q <= '0;
			fmt_q     <= '0;
			chan_q    <= '0;
			rate_q    <= '0;
			bits_q    <= '0;
			done_q    <= 1'b0;
		end else if (advance) begin
			phase_q   <= n_phase;
			idx_q     <= n_idx;
			word_q    <= n_word;
			skip_q    <= n_skip;
			fmt_len_q <= n_fmt_len;
			fmt_q     <= n_fmt;
			chan_q    <= n_chan;
			rate_q    <= n_rate;
			bits_q    <= n_bits;
			done_q    <= n_done;
		end
	end

endmodule

### rtl/core/wav_header_parser.sv
// ----------------------------------------------------------------------------
// wav_header_parser
// Byte-stream parser for the RIFF/WAVE header of a PCM WAV file.
// ----------------------------------------------------------------------------
// Feed the file one byte per transfer on the input channel; first_byte restarts
// parsing at that byte (parsing also starts from reset without it), and
// final_byte marks the last byte of the file. The block checks the RIFF and
// WAVE tags, skips whole chunks by size until the fmt chunk, reads format,
// channel count, sample rate and bits per sample (following the extensible
// subformat when present), requires PCM, and then a data chunk. At most one
// result transfer goes out per parse, on the byte that decides it: status 0
// with the header fields and the data chunk length, or an error code (1 no
// RIFF, 2 no WAVE, 3 not PCM, 4 no data tag, 5 truncated by final_byte).
// On error data_size is zero and the other fields carry what was read so
// far. Later bytes are swallowed until the next first_byte. Odd-size chunk
// padding is not handled. Throughput is one byte per clock, but for the
// output hold below: each byte passes an input register, one step of the
// parse state logic and, when it yields a result, the result register.
// Bytes that yield no result keep flowing while a result waits on the
// output; only a byte that would produce a second result waits there.
// ----------------------------------------------------------------------------
module wav_header_parser
	import wav_hdr_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	// byte input channel
	input  logic         in_valid,
	output logic         in_stall,
	input  wav_hdr_in_t  in_item,
	// result output channel
	output logic         out_valid,
	input  logic         out_stall,
	output wav_hdr_out_t out_item
);

	// input register stage
	logic         s1_valid_q;
	wav_hdr_in_t  item_s1;

	// step results
	logic         emit;
	wav_hdr_out_t step_res;
	logic         advance;

	// result register
	logic         out_valid_q;
	wav_hdr_out_t out_item_q;

	// a byte in stage one moves on unless it makes a result and the
	// result register is full and held
	assign advance  = s1_valid_q && (!out_valid_q || !out_stall || !emit);
	assign in_stall = s1_valid_q && !advance;

	wav_hdr_fsm u_fsm (
		.clk     (clk),
		.arst_n  (arst_n),
		.valid   (s1_valid_q),
		.advance (advance),
		.item    (item_s1),
		.emit    (emit),
		.result  (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_valid && !in_stall) begin
			s1_valid_q <= 1'b1;
		end else if (advance) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			out_item_q <= step_res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

`ifndef SYNTHESIS
	// stall only while stage one is occupied
	a_stall_needs_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> s1_valid_q)
		else $error("input stalled with empty stage one");

	// a new result never overwrites one that is still held
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && emit) |-> (!out_valid_q || !out_stall))
		else $error("result register overwritten while held");

	// status stays within the defined codes
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_item_q.status <= ST_TRUNC))
		else $error("undefined status code");

	// data size is only reported with a good header
	a_len_on_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_item_q.status != ST_OK)) |-> (out_item_q.data_size == '0))
		else $error("data size set on failed parse");
`endif

endmodule

### sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Streams WAV files, whole, cut short, corrupted or pure noise, one byte per
// transfer into wav_header_parser, predicts the result, if any, of each parse and
// checks every result field by field. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
	import wav_hdr_pkg::*;

	localparam int CLK_HALF      = 10;
	localparam int RESET_CYCLES  = 11;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int SETTLE_CYCLES = 8;       // pipeline is two deep; a little slack
	localparam int HOLD_CYCLES   = 300;     // long receiver hold-off
	localparam int RANDOM_BYTES  = 100;
	localparam int MIN_FILES     = 2;       // results are one per file at most
	localparam int MAX_REPORTS   = 100;

	// Parse phases of the header walk, in file order
	typedef enum logic [4:0] {
		P_RIFF, P_RSIZE, P_WAVE, P_CID, P_CSIZE, P_CSKIP, P_FSIZE,
		P_FORMAT, P_CHAN, P_RATE, P_BRATE, P_ALIGN, P_BITS, P_EXT1,
		P_SUBFMT, P_EXT2, P_FSKIP, P_DID, P_DSIZE
	} parse_phase_t;

	logic         clk;
	logic         arst_n;
	logic         in_valid;
	logic         in_stall;
	wav_hdr_in_t  in_item;
	logic         out_valid;
	logic         out_stall;
	wav_hdr_out_t out_item;

	// Predicted header parser state
	parse_phase_t ph;
	logic [1:0]   idx;
	logic [31:0]  word;
	logic [31:0]  skip_left;
	logic [31:0]  fmt_len;
	logic [15:0]  fmt_code;
	logic [15:0]  chans;
	logic [31:0]  rate;
	logic [15:0]  bits;
	logic         hdr_done;

	wav_hdr_out_t pending_headers[$];   // results still owed by the block
	logic [7:0]   file_bytes[$];        // file under construction

	int error_count = 0;
	int bytes_sent  = 0;
	int cycle_count = 0;
	bit calm        = 1'b0;             // no random idling on either side while set
	bit hold_request = 1'b0;
	bit hold_active  = 1'b0;

	wav_header_parser u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// Watchdog: a run that hangs on a missing result ends here
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("TB_ERROR");
		$finish;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------
	function automatic void clear_parse_state();
		ph        = P_RIFF;
		idx       = 2'd0;
		word      = '0;
		skip_left = '0;
		fmt_len   = '0;
		fmt_code  = '0;
		chans     = '0;
		rate      = '0;
		bits      = '0;
		hdr_done  = 1'b0;
	endfunction

	// A zero count skips nothing and moves straight on
	function automatic void begin_skip(input logic [31:0] count, input parse_phase_t skip_ph,
			input parse_phase_t next_ph);
		if (count == 0) begin
			ph = next_ph;
		end else begin
			skip_left = count;
			ph = skip_ph;
		end
	endfunction

	// One accepted byte; queues the result it decides, if any
	task automatic parse_header_byte(input wav_hdr_in_t it);
		logic         decided;
		logic [2:0]   st;
		logic [31:0]  v;
		logic         two_byte;
		wav_hdr_out_t res;

		if (it.first_byte)
			clear_parse_state();
		if (hdr_done)
			return;
		decided = 1'b0;
		st = ST_OK;

		if (ph == P_CSKIP || ph == P_EXT1 || ph == P_EXT2 || ph == P_FSKIP) begin
			skip_left = skip_left - 32'd1;
			if (skip_left == 0) begin
				case (ph)
					P_CSKIP: ph = P_CID;
					P_EXT1:  ph = P_SUBFMT;
					P_EXT2:  begin_skip(fmt_len - EXT_FMT_BYTES, P_FSKIP, P_DID);
					default: ph = P_DID;
				endcase
			end
		end else begin
			two_byte = (ph == P_FORMAT) || (ph == P_CHAN) || (ph == P_ALIGN) ||
				(ph == P_BITS) || (ph == P_SUBFMT);
			// little-endian assembly: newest byte enters at the top
			word = {it.in_byte, word[31:8]};
			if ((two_byte && idx < 2'd1) || (!two_byte && idx < 2'd3)) begin
				idx = idx + 2'd1;
			end else begin
				idx = 2'd0;
				v = two_byte ? {16'h0000, word[31:16]} : word;
				case (ph)
					P_RIFF: begin
						if (v != TAG_RIFF) begin
							decided = 1'b1;
							st = ST_NO_RIFF;
						end else ph = P_RSIZE;
					end
					P_RSIZE: ph = P_WAVE;
					P_WAVE: begin
						if (v != TAG_WAVE) begin
							decided = 1'b1;
							st = ST_NO_WAVE;
						end else ph = P_CID;
					end
					P_CID:   ph = (v == TAG_FMT) ? P_FSIZE : P_CSIZE;
					P_CSIZE: begin_skip(v, P_CSKIP, P_CID);
					P_FSIZE: begin
						fmt_len = v;
						ph = P_FORMAT;
					end
					P_FORMAT: begin
						fmt_code = v[15:0];
						ph = P_CHAN;
					end
					P_CHAN: begin
						chans = v[15:0];
						ph = P_RATE;
					end
					P_RATE: begin
						rate = v;
						ph = P_BRATE;
					end
					P_BRATE: ph = P_ALIGN;
					P_ALIGN: ph = P_BITS;
					P_BITS: begin
						bits = v[15:0];
						if (fmt_code == FMT_EXTENSIBLE) begin
							skip_left = EXT_SKIP_FIRST;
							ph = P_EXT1;
						end else if (fmt_code != FMT_PCM) begin
							decided = 1'b1;
							st = ST_NOT_PCM;
						end else begin
							// too small a fmt size wraps into a very long skip
							begin_skip(fmt_len - BASIC_FMT_BYTES, P_FSKIP, P_DID);
						end
					end
					P_SUBFMT: begin
						// subformat is judged before the trailing 14 bytes
						fmt_code = v[15:0];
						if (fmt_code != FMT_PCM) begin
							decided = 1'b1;
							st = ST_NOT_PCM;
						end else begin
							skip_left = EXT_SKIP_SECOND;
							ph = P_EXT2;
						end
					end
					P_DID: begin
						if (v != TAG_DATA) begin
							decided = 1'b1;
							st = ST_NO_DATA;
						end else ph = P_DSIZE;
					end
					default: begin
						decided = 1'b1;
						st = ST_OK;
					end
				endcase
			end
		end

		// last byte of the file with the header still open
		if (!decided && it.final_byte) begin
			decided = 1'b1;
			st = ST_TRUNC;
		end
		if (decided) begin
			hdr_done = 1'b1;
			res.status          = st;
			res.channel_count   = chans;
			res.rate_hz         = rate;
			res.bits_per_sample = bits;
			res.data_size       = (st == ST_OK) ? word : 32'd0;
			pending_headers.push_back(res);
		end
	endtask

	// ------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------
	task automatic flag_mismatch(input string msg);
		error_count++;
		if (error_count <= MAX_REPORTS)
			$display("[%0t] mismatch: %s", $time, msg);
	endtask

	task automatic check_result(input wav_hdr_out_t got);
		wav_hdr_out_t want;

		if (pending_headers.size() == 0) begin
			flag_mismatch($sformatf("result with no header pending, status %0d", got.status));
			return;
		end
		want = pending_headers.pop_front();
		if (got.status !== want.status)
			flag_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
		if (got.channel_count !== want.channel_count)
			flag_mismatch($sformatf("channel_count %h, expected %h",
				got.channel_count, want.channel_count));
		if (got.rate_hz !== want.rate_hz)
			flag_mismatch($sformatf("rate_hz %h, expected %h", got.rate_hz, want.rate_hz));
		if (got.bits_per_sample !== want.bits_per_sample)
			flag_mismatch($sformatf("bits_per_sample %h, expected %h",
				got.bits_per_sample, want.bits_per_sample));
		if (got.data_size !== want.data_size)
			flag_mismatch($sformatf("data_size %h, expected %h",
				got.data_size, want.data_size));
	endtask

	// Both channels are sampled at the edge that completes a transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				check_result(out_item);
			if (in_valid && !in_stall)
				parse_header_byte(in_item);
		end
	end

	// ------------------------------------------------------------------
	// Idling
	// ------------------------------------------------------------------
	// Mostly back to back, some short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Receiver: random stall bursts, or one long hold-off on request
	initial begin : receiver
		int n;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_active = 1'b1;
				out_stall <= 1'b1;
				for (n = 0; n < HOLD_CYCLES; n++)
					@(posedge clk);
				out_stall <= 1'b0;
				hold_active = 1'b0;
			end else if (!calm && $urandom_range(0, 2) == 0) begin
				n = 1 + pick_gap();
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	// One byte transfer; valid stays high afterwards so the next byte can
	// follow without a bubble
	task automatic send_byte(input logic [7:0] b, input logic is_first, input logic is_last);
		int gap;
		wav_hdr_in_t item;

		gap = calm ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item.in_byte    = b;
		item.first_byte = is_first;
		item.final_byte = is_last;
		in_valid <= 1'b1;
		in_item  <= item;
		do @(posedge clk); while (in_stall);
		bytes_sent++;
	endtask

	task automatic send_file(input bit with_first, input bit with_final);
		int k;
		for (k = 0; k < file_bytes.size(); k++)
			send_byte(file_bytes[k], with_first && k == 0,
				with_final && k == file_bytes.size() - 1);
	endtask

	// Sender holds off until every owed result is out, then lets the
	// pipeline settle, after first letting the last transfer be predicted
	task automatic finish_pending();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_headers.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic void push_le(input logic [31:0] v, input int n);
		int k;
		for (k = 0; k < n; k++)
			file_bytes.push_back(v[8*k +: 8]);
	endfunction

	function automatic void trim_file(input int keep);
		while (file_bytes.size() > keep)
			file_bytes.delete(file_bytes.size() - 1);
	endfunction

	// RIFF/WAVE file up to the data length; unknown chunks go before fmt,
	// the first of several is empty. fmt_extra adjusts the fmt chunk size
	// past its standard length (negative makes it too short).
	task automatic build_wav(input logic [15:0] fcode, input logic [15:0] sub,
			input logic [15:0] nch, input logic [31:0] rate_v, input logic [15:0] nbits,
			input int fmt_extra, input int nchunks, input logic [31:0] dtag,
			input logic [31:0] dlen);
		int c, k, csize;
		logic [31:0] cid, fsize;

		file_bytes.delete();
		push_le(TAG_RIFF, 4);
		push_le($urandom, 4);
		push_le(TAG_WAVE, 4);
		for (c = 0; c < nchunks; c++) begin
			cid = $urandom;
			if (cid == TAG_FMT)
				cid = TAG_DATA;
			csize = (c == 0 && nchunks > 1) ? 0 : $urandom_range(1, 10);
			push_le(cid, 4);
			push_le(csize, 4);
			for (k = 0; k < csize; k++)
				push_le($urandom, 1);
		end
		fsize = ((fcode == FMT_EXTENSIBLE) ? EXT_FMT_BYTES : BASIC_FMT_BYTES) + fmt_extra;
		push_le(TAG_FMT, 4);
		push_le(fsize, 4);
		push_le({16'h0000, fcode}, 2);
		push_le({16'h0000, nch}, 2);
		push_le(rate_v, 4);
		push_le($urandom, 4);   // byte rate
		push_le($urandom, 2);   // block align
		push_le({16'h0000, nbits}, 2);
		if (fcode == FMT_EXTENSIBLE) begin
			for (k = 0; k < 8; k++)
				push_le($urandom, 1);
			push_le({16'h0000, sub}, 2);
			for (k = 0; k < 14; k++)
				push_le($urandom, 1);
		end
		for (k = 0; k < fmt_extra; k++)
			push_le($urandom, 1);
		push_le(dtag, 4);
		push_le(dlen, 4);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	// No restart flag: parsing runs straight out of reset. All-ones fields,
	// and final set on the very byte that completes the header.
	task automatic test_start_from_reset();
		build_wav(FMT_PCM, FMT_PCM, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 0, 0,
			TAG_DATA, 32'hFFFF_FFFF);
		send_file(1'b0, 1'b1);
		finish_pending();
	endtask

	task automatic test_tag_errors();
		build_wav(FMT_PCM, FMT_PCM, 16'd2, 32'd44100, 16'd16, 0, 0, TAG_DATA, 32'd100);
		file_bytes[0] = file_bytes[0] ^ 8'h20;          // "rIFF"
		send_file(1'b1, 1'b1);
		build_wav(FMT_PCM, FMT_PCM, 16'd2, 32'd44100, 16'd16, 0, 0, TAG_DATA, 32'd100);
		file_bytes[11] = file_bytes[11] ^ 8'h01;        // bad WAVE tag
		send_file(1'b1, 1'b1);
		build_wav(FMT_PCM, FMT_PCM, 16'd1, 32'd8000, 16'd8, 0, 1, TAG_FMT, 32'd7);
		send_file(1'b1, 1'b1);                          // fmt where data belongs
		finish_pending();
	endtask

	task automatic test_format_codes();
		build_wav(16'h0003, FMT_PCM, 16'd2, 32'd48000, 16'd32, 0, 0, TAG_DATA, 32'd64);
		send_file(1'b1, 1'b1);                          // float, not PCM
		build_wav(16'h0000, FMT_PCM, 16'd1, 32'd8000, 16'd8, 0, 0, TAG_DATA, 32'd64);
		send_file(1'b1, 1'b1);
		// extensible PCM, all-zero fields, fmt size exactly 40
		build_wav(FMT_EXTENSIBLE, FMT_PCM, 16'd0, 32'd0, 16'd0, 0, 0, TAG_DATA, 32'd0);
		send_file(1'b1, 1'b1);
		// extensible with float subformat: rejected before the last 14 bytes
		build_wav(FMT_EXTENSIBLE, 16'h0003, 16'd6, 32'd96000, 16'd24, 0, 0, TAG_DATA, 32'd9);
		send_file(1'b1, 1'b1);
		// PCM with cbSize fields: extra fmt bytes get skipped
		build_wav(FMT_PCM, FMT_PCM, 16'd2, 32'd22050, 16'd16, 22, 0, TAG_DATA, 32'd512);
		send_file(1'b1, 1'b1);
		// extensible with a longer fmt chunk
		build_wav(FMT_EXTENSIBLE, FMT_PCM, 16'd8, 32'd192000, 16'd24, 6, 0, TAG_DATA, 32'd3);
		send_file(1'b1, 1'b1);
		finish_pending();
	endtask

	task automatic test_chunk_skipping();
		int k;
		// empty chunk then two sized ones ahead of fmt
		build_wav(FMT_PCM, FMT_PCM, 16'd2, 32'd44100, 16'd16, 0, 3, TAG_DATA, 32'h1234_5678);
		// bytes after the result are swallowed, final flag included
		for (k = 0; k < 5; k++)
			push_le($urandom, 1);
		send_file(1'b1, 1'b1);
		finish_pending();
	endtask

	task automatic test_truncation();
		send_byte(8'h52, 1'b1, 1'b1);                   // file of one byte
		build_wav(FMT_PCM, FMT_PCM, 16'd2, 32'd44100, 16'd16, 0, 1, TAG_DATA, 32'd10);
		trim_file(30);
		send_file(1'b1, 1'b1);
		// fmt size 14 wraps into a huge skip that the end of file cuts off
		build_wav(FMT_PCM, FMT_PCM, 16'd2, 32'd44100, 16'd16, -2, 0, TAG_DATA, 32'd10);
		send_file(1'b1, 1'b1);
		// open header without final, then a restart on a fresh file
		build_wav(FMT_PCM, FMT_PCM, 16'd1, 32'd11025, 16'd8, 0, 0, TAG_DATA, 32'd5);
		trim_file(20);
		send_file(1'b1, 1'b0);
		build_wav(FMT_PCM, FMT_PCM, 16'd1, 32'd11025, 16'd8, 0, 0, TAG_DATA, 32'd5);
		send_file(1'b1, 1'b0);
		finish_pending();
	endtask

	// Receiver holds off while one-byte files keep coming: the result
	// register and the stage behind it fill and the input stalls
	task automatic test_backpressure();
		int k;
		calm = 1'b1;
		hold_request = 1'b1;
		wait (hold_active);
		for (k = 0; k < 8; k++)
			send_byte(8'($urandom), 1'b1, 1'b1);
		build_wav(FMT_PCM, FMT_PCM, 16'd2, 32'd44100, 16'd16, 0, 0, TAG_DATA, 32'd88);
		send_file(1'b1, 1'b1);
		calm = 1'b0;
		finish_pending();
	endtask

	task automatic make_random_file();
		logic [15:0] fcode, sub, nch, nbits;
		logic [31:0] rate_v, dlen, dtag;
		int          r, extra, nchunks, k, cut, pick;
		logic [7:0]  saved[$];

		r = $urandom_range(0, 99);
		fcode = ($urandom_range(0, 3) == 0) ? FMT_EXTENSIBLE : FMT_PCM;
		sub = FMT_PCM;
		dtag = TAG_DATA;
		if ($urandom_range(0, 4) == 0)
			nch = 16'($urandom);
		else
			nch = 16'($urandom_range(1, 8));
		if ($urandom_range(0, 3) == 0)
			rate_v = $urandom;
		else
			rate_v = $urandom_range(8000, 192000);
		if ($urandom_range(0, 3) == 0)
			nbits = 16'($urandom);
		else
			nbits = 16'(8 * $urandom_range(1, 4));
		dlen = $urandom;
		pick = $urandom_range(0, 9);
		if (pick < 6)
			extra = 0;
		else if (pick < 8)
			extra = 2 * $urandom_range(1, 4);
		else if (pick == 8)
			extra = 22;
		else
			extra = -$urandom_range(1, 4);
		nchunks = $urandom_range(0, 3);

		// wrong format, subformat or data tag
		if (r >= 80 && r < 88) begin
			if (fcode == FMT_EXTENSIBLE) begin
				sub = 16'($urandom);
				if (sub == FMT_PCM)
					sub = 16'h0003;
			end else if ($urandom_range(0, 1) == 0) begin
				fcode = 16'($urandom);
				if (fcode == FMT_PCM || fcode == FMT_EXTENSIBLE)
					fcode = 16'h0003;
			end else begin
				dtag = $urandom;
			end
		end

		build_wav(fcode, sub, nch, rate_v, nbits, extra, nchunks, dtag, dlen);
		for (k = $urandom_range(0, 4); k > 0; k--)
			push_le($urandom, 1);

		if (r >= 55 && r < 70) begin
			k = $urandom_range(0, file_bytes.size() - 1);
			file_bytes[k] = file_bytes[k] ^ 8'($urandom_range(1, 255));
			send_file(1'b1, $urandom_range(0, 4) != 0);
		end else if (r >= 70 && r < 80) begin
			trim_file($urandom_range(1, file_bytes.size() - 1));
			send_file(1'b1, 1'b1);
		end else if (r >= 88 && r < 94) begin
			file_bytes.delete();
			for (k = $urandom_range(1, 20); k > 0; k--)
				push_le($urandom, 1);
			send_file(1'b1, $urandom_range(0, 1) != 0);
		end else if (r >= 94 && $urandom_range(0, 1) == 0) begin
			// no restart flag: carries on from whatever state is left
			send_file(1'b0, $urandom_range(0, 1) != 0);
		end else if (r >= 94) begin
			// restart in the middle of an unfinished header
			saved = file_bytes;
			cut = $urandom_range(1, file_bytes.size() - 1);
			trim_file(cut);
			send_file(1'b1, 1'b0);
			file_bytes = saved;
			send_file(1'b1, 1'b1);
		end else begin
			send_file(1'b1, $urandom_range(0, 4) != 0);
		end
	endtask

	task automatic test_random_files();
		int start_bytes, files;
		start_bytes = bytes_sent;
		files = 0;
		while (bytes_sent - start_bytes < RANDOM_BYTES || files < MIN_FILES) begin
			calm = ($urandom_range(0, 7) == 0);
			make_random_file();
			files++;
			if ($urandom_range(0, 9) == 0)
				finish_pending();
		end
		calm = 1'b0;
		finish_pending();
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n   = 1'b0;
		in_valid = 1'b0;
		in_item  = '0;
		clear_parse_state();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_start_from_reset();
		test_tag_errors();
		test_format_codes();
		test_chunk_skipping();
		test_truncation();
		test_backpressure();
		test_random_files();

		if (error_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

### sim.f
rtl/core/wav_hdr_pkg.sv
rtl/core/wav_hdr_fsm.sv
rtl/core/wav_header_parser.sv
sim/testbench.sv
